/* rtl/core/relay_on_time_watchdog_macros.svh */
// Assertion helpers for the relay on-time watchdog.
// Both forms expect clk and rst_n in scope.
`ifndef RELAY_ON_TIME_WATCHDOG_MACROS_SVH
`define RELAY_ON_TIME_WATCHDOG_MACROS_SVH

`ifndef SYNTHESIS

`define RTW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtw: same-cycle check failed");

`define RTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtw: next-cycle check failed");

`else

`define RTW_ASSERT_NOW(label, ante, cons)

`define RTW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/rtw_pkg.sv */
`default_nettype none

package rtw_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_MAX_ON   = 2'd0,
        REG_WINDOW   = 2'd1,
        REG_COOLDOWN = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_t;

    localparam logic [31:0] MAX_ON_RESET   = 32'd1800000;
    localparam logic [31:0] WINDOW_RESET   = 32'd7200000;
    localparam logic [31:0] COOLDOWN_RESET = 32'd300000;

    typedef struct packed {
        logic [31:0] max_on;
        logic [31:0] window;
        logic [31:0] cooldown;
    } cfg_t;

    typedef struct packed {
        logic        tripped;
        logic        trip_event;
        logic        cleared_event;
        logic [31:0] total_on_ms;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/rtw_cfg_regs.sv */
`default_nettype none

module rtw_cfg_regs
    import rtw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MAX_ON:   cfg_next.max_on   = pwdata;
                REG_WINDOW:   cfg_next.window   = pwdata;
                REG_COOLDOWN: cfg_next.cooldown = pwdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_on   <= MAX_ON_RESET;
            cfg_reg.window   <= WINDOW_RESET;
            cfg_reg.cooldown <= COOLDOWN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAX_ON:   prdata = cfg_reg.max_on;
            REG_WINDOW:   prdata = cfg_reg.window;
            REG_COOLDOWN: prdata = cfg_reg.cooldown;
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/rtw_step.sv */
`default_nettype none

module rtw_step
    import rtw_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [31:0] now_ms,
    input  wire logic        relay_on,
    input  wire cfg_t        cfg,
    output result_t          result
);

    // compare width covers both the time values and the 32-bit registers
    localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TIME_BITS-1:0] acc_reg,  acc_next;
    logic [TIME_BITS-1:0] win_reg,  win_next;
    logic [TIME_BITS-1:0] seg_reg,  seg_next;
    logic [TIME_BITS-1:0] off_reg,  off_next;
    logic                 trip_reg, trip_next;
    logic                 prev_reg, prev_next;

    logic [CW-1:0]        now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] total;
    logic [CW-1:0]        total_ext;
    logic                 edge_seen;
    logic                 trip_ev;
    logic                 clr_ev;
    // elapsed times, wrapped at TIME_BITS before widening for the compare
    logic [TIME_BITS-1:0] cool_el;
    logic [TIME_BITS-1:0] win_el;

    assign now_ext = CW'(now_ms);
    assign now_t   = now_ext[TIME_BITS-1:0];
    assign cool_el = now_t - off_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        win_next  = win_reg;
        seg_next  = seg_reg;
        off_next  = off_reg;
        trip_next = trip_reg;
        trip_ev   = 1'b0;
        clr_ev    = 1'b0;
        edge_seen = (relay_on != prev_reg);
        total     = acc_reg;
        win_el    = '0;

        if (trip_reg && !relay_on)
        begin
            // cooldown only; zero in off_reg means not yet started
            if (off_reg == '0)
            begin
                off_next = now_t;
            end
            else if (CW'(cool_el) >= CW'(cfg.cooldown))
            begin
                win_next  = '0;
                acc_next  = '0;
                trip_next = 1'b0;
                off_next  = '0;
                clr_ev    = 1'b1;
            end
            total = acc_next;
        end
        else
        begin
            if (edge_seen && !relay_on)
            begin
                if (seg_reg != '0)
                begin
                    acc_next = acc_reg + (now_t - seg_reg);
                end
                off_next = now_t;
            end
            if (edge_seen && relay_on)
            begin
                seg_next = now_t;
                off_next = '0;
                if (win_reg == '0)
                begin
                    win_next = now_t;
                end
            end
            if (relay_on)
            begin
                win_el = now_t - win_next;
                // window expired: restart accounting at this sample
                if (win_next != '0 && CW'(win_el) >= CW'(cfg.window))
                begin
                    win_next = now_t;
                    acc_next = '0;
                    seg_next = now_t;
                end
                total = acc_next + (now_t - seg_next);
                if (CW'(total) >= CW'(cfg.max_on) && !trip_reg)
                begin
                    trip_next = 1'b1;
                    off_next  = now_t;
                    trip_ev   = 1'b1;
                end
            end
            else
            begin
                total = acc_next;
            end
        end
        prev_next = relay_on;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            win_reg  <= '0;
            seg_reg  <= '0;
            off_reg  <= '0;
            trip_reg <= 1'b0;
            prev_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            win_reg  <= win_next;
            seg_reg  <= seg_next;
            off_reg  <= off_next;
            trip_reg <= trip_next;
            prev_reg <= prev_next;
        end
    end

    assign total_ext = CW'(total);

    always_comb
    begin
        result.tripped       = trip_next;
        result.trip_event    = trip_ev;
        result.cleared_event = clr_ev;
        result.total_on_ms   = total_ext[31:0];
    end

endmodule

`default_nettype wire

/* rtl/core/relay_on_time_watchdog.sv */
// Relay on-time watchdog. Each input word carries a millisecond timestamp and the
// sensed relay state and yields exactly one result word: trip flag, trip and clear
// events, and the ON time counted in the current window. One word is accepted per
// clock while out_ready is high; a word is held in the input register and its result
// is loaded into the output register when it advances, which sets out_valid. A
// result held by out_ready low freezes the input register, and in_ready drops once
// it is full. The step logic (wrap-around subtracts, two adds and compares at
// TIME_BITS width) between those two registers sets the clock rate. A stored time
// of zero reads as unset, as at reset. Configuration (max ON time, window, cooldown)
// is written over the APB port at byte addresses 0, 4 and 8; the user must write it
// only while no word is in flight, which the block does not enforce.
`default_nettype none

`include "relay_on_time_watchdog_macros.svh"

module relay_on_time_watchdog
    import rtw_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           now_ms,
    input  wire logic                  relay_on,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       tripped,
    output logic                       trip_event,
    output logic                       cleared_event,
    output logic [31:0]                total_on_ms
);

    cfg_t        cfg;
    result_t     step_res;
    result_t     res_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_now_reg;
    logic        s1_relay_reg;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        in_accept;

    assign pready = 1'b1;

    rtw_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // move a word from the input register to the result register
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    rtw_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .now_ms   (s1_now_reg),
        .relay_on (s1_relay_reg),
        .cfg      (cfg),
        .result   (step_res)
    );

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_now_reg   <= now_ms;
            s1_relay_reg <= relay_on;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tripped       = res_reg.tripped;
    assign trip_event    = res_reg.trip_event;
    assign cleared_event = res_reg.cleared_event;
    assign total_on_ms   = res_reg.total_on_ms;

    `RTW_ASSERT_NOW(a_events_exclusive, out_valid_reg, !(trip_event && cleared_event))
    `RTW_ASSERT_NOW(a_trip_sets_flag, out_valid_reg && trip_event, tripped)
    `RTW_ASSERT_NOW(a_clear_drops_flag, out_valid_reg && cleared_event, !tripped)
    `RTW_ASSERT_NEXT(a_accept_loads_stage, in_accept, s1_valid_reg)

endmodule

`default_nettype wire

/* test/testbench.sv */
module testbench;
    import rtw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] stamp;
        logic        relay;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [31:0]           now_ms = '0;
    logic                  relay_on = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  tripped;
    logic                  trip_event;
    logic                  cleared_event;
    logic [31:0]           total_on_ms;

    relay_on_time_watchdog i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .relay_on      (relay_on),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tripped       (tripped),
        .trip_event    (trip_event),
        .cleared_event (cleared_event),
        .total_on_ms   (total_on_ms)
    );

    sample_t     sample_queue[$];
    result_t     predicted_status[$];
    int          errors = 0;
    int unsigned cycle_count = 0;
    int unsigned feed_gap_pct = 0;
    int unsigned drain_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    logic [31:0] sim_clock = 32'd1;
    logic        run_relay = 1'b0;

    // watchdog mirror
    cfg_t        watch_cfg = '{max_on: MAX_ON_RESET, window: WINDOW_RESET,
                               cooldown: COOLDOWN_RESET};
    logic [31:0] wd_accum = '0;
    logic [31:0] wd_win_start = '0;
    logic [31:0] wd_seg_start = '0;
    logic [31:0] wd_off_start = '0;
    logic        wd_tripped = 1'b0;
    logic        wd_prev_relay = 1'b0;

    function automatic result_t watchdog_step(input logic [31:0] now, input logic relay);
        result_t     r;
        logic        toggled;
        logic [31:0] elapsed;
        r = '0;
        toggled = (relay != wd_prev_relay);
        r.total_on_ms = wd_accum;
        if (wd_tripped && !relay)
        begin
            // tripped and OFF: only the cooldown runs
            if (wd_off_start == 0)
            begin
                wd_off_start = now;
            end
            else
            begin
                elapsed = now - wd_off_start;
                if (elapsed >= watch_cfg.cooldown)
                begin
                    wd_win_start = '0;
                    wd_accum = '0;
                    wd_tripped = 1'b0;
                    wd_off_start = '0;
                    r.cleared_event = 1'b1;
                end
            end
            r.total_on_ms = wd_accum;
        end
        else
        begin
            if (toggled && !relay)
            begin
                if (wd_seg_start != 0)
                begin
                    elapsed = now - wd_seg_start;
                    wd_accum = wd_accum + elapsed;
                end
                wd_off_start = now;
            end
            if (toggled && relay)
            begin
                wd_seg_start = now;
                wd_off_start = '0;
                if (wd_win_start == 0)
                    wd_win_start = now;
            end
            if (relay)
            begin
                elapsed = now - wd_win_start;
                if (wd_win_start != 0 && elapsed >= watch_cfg.window)
                begin
                    wd_win_start = now;
                    wd_accum = '0;
                    wd_seg_start = now;
                end
                elapsed = now - wd_seg_start;
                r.total_on_ms = wd_accum + elapsed;
                if (r.total_on_ms >= watch_cfg.max_on && !wd_tripped)
                begin
                    wd_tripped = 1'b1;
                    wd_off_start = now;
                    r.trip_event = 1'b1;
                end
            end
            else
            begin
                r.total_on_ms = wd_accum;
            end
        end
        wd_prev_relay = relay;
        r.tripped = wd_tripped;
        return r;
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin : feed
            sample_t s;
            if (in_valid && in_ready)
                predicted_status.push_back(watchdog_step(now_ms, relay_on));
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= feed_gap_pct)
                begin
                    s = sample_queue.pop_front();
                    in_valid <= 1'b1;
                    now_ms   <= s.stamp;
                    relay_on <= s.relay;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_served <= 0;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin : drain
            result_t want;
            if (out_valid && out_ready)
            begin
                if (predicted_status.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual %h", $time,
                             {tripped, trip_event, cleared_event, total_on_ms});
                    errors++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    check_field("tripped", want.tripped, tripped);
                    check_field("trip_event", want.trip_event, trip_event);
                    check_field("cleared_event", want.cleared_event, cleared_event);
                    check_field("total_on_ms", want.total_on_ms, total_on_ms);
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= drain_stall_pct);
        end
    end

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MAX_ON:   watch_cfg.max_on = value;
            REG_WINDOW:   watch_cfg.window = value;
            REG_COOLDOWN: watch_cfg.cooldown = value;
            default:      ;
        endcase
        // read it back
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", value, readback);
    endtask

    task automatic set_config(input logic [31:0] max_on, input logic [31:0] window,
                              input logic [31:0] cooldown);
        cfg_write(REG_MAX_ON, max_on);
        cfg_write(REG_WINDOW, window);
        cfg_write(REG_COOLDOWN, cooldown);
        @(negedge clk);
    endtask

    task automatic add_sample(input logic [31:0] stamp, input logic relay);
        sample_queue.push_back('{stamp: stamp, relay: relay});
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || predicted_status.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // mostly a plausible timeline with relay toggling, some noise and wrap jumps
    task automatic add_timeline(input int count, input logic [31:0] max_step);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 7)
            begin
                add_sample($urandom, $urandom_range(1));
            end
            else
            begin
                if (pick < 9)
                    sim_clock = 32'hFFFF_FF00 + $urandom_range(255);
                else if (pick < 10)
                    sim_clock = $urandom;
                if ($urandom_range(99) < 18)
                    run_relay = ~run_relay;
                sim_clock = sim_clock + $urandom_range(max_step);
                add_sample(sim_clock, run_relay);
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] max_on, input logic [31:0] window,
                             input logic [31:0] cooldown, input logic [31:0] max_step,
                             input int unsigned idle_pct, input logic with_hold,
                             input int count);
        set_config(max_on, window, cooldown);
        feed_gap_pct = idle_pct;
        drain_stall_pct = idle_pct;
        if (with_hold)
        begin
            @(posedge clk);
            hold_requests <= hold_requests + 1;
            @(negedge clk);
        end
        add_timeline(count, max_step);
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        feed_gap_pct = 24;
        drain_stall_pct = 24;

        // reset settings: zero timestamp, OFF edge with no segment, trip, cooldown, wrap
        add_sample(32'd0, 1'b1);
        add_sample(32'd5, 1'b1);
        add_sample(32'd6, 1'b0);
        add_sample(32'd100, 1'b1);
        add_sample(32'd1900100, 1'b1);
        add_sample(32'd1900200, 1'b1);
        add_sample(32'd1900300, 1'b0);
        add_sample(32'd2300000, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b1);
        add_sample(32'h0000_0100, 1'b1);
        add_sample(32'h0000_0200, 1'b0);
        wait_idle();

        // window expiry while ON
        set_config(32'd100, 32'd1000, 32'd50);
        add_sample(32'd1000, 1'b1);
        add_sample(32'd1050, 1'b1);
        add_sample(32'd1060, 1'b0);
        add_sample(32'd1070, 1'b1);
        add_sample(32'd2100, 1'b1);
        add_sample(32'd2150, 1'b0);
        add_sample(32'd2160, 1'b0);
        wait_idle();

        // all registers zero
        set_config(32'd0, 32'd0, 32'd0);
        add_sample(32'd10, 1'b1);
        add_sample(32'd20, 1'b1);
        add_sample(32'd30, 1'b0);
        add_sample(32'd40, 1'b0);
        add_sample(32'd50, 1'b0);
        add_sample(32'd60, 1'b1);
        wait_idle();

        run_phase(32'd100, 32'd400, 32'd60, 32'd20, 24, 1'b0, 200);
        run_phase(32'd37, 32'd1000, 32'd500, 32'd40, 0, 1'b0, 200);
        run_phase(32'd1, 32'd1, 32'd1, 32'd3, 24, 1'b0, 150);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000, 24, 1'b0, 150);
        run_phase($urandom_range(300, 1), $urandom_range(300, 1), $urandom_range(300, 1),
                  32'd30, 24, 1'b1, 200);
        run_phase(32'd500, 32'd2000, 32'd100, 32'd50, 24, 1'b0, 250);
        run_phase(MAX_ON_RESET, WINDOW_RESET, COOLDOWN_RESET, 32'd200000, 24, 1'b0, 150);
        run_phase($urandom_range(200, 1), $urandom_range(800, 1), $urandom_range(200, 1),
                  32'd25, 24, 1'b0, 300);

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rtw_pkg.sv
rtl/core/rtw_cfg_regs.sv
rtl/core/rtw_step.sv
rtl/core/relay_on_time_watchdog.sv
test/testbench.sv
